FILE: hw/rtl/plte_pkg.sv
// ----------------------------------------------------------------------------
// plte_pkg
// Shared types for the packed list table engine: operation and status codes
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plte_pkg;

   typedef enum logic [1:0] {
      MODE_FIND   = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_APPEND = 2'd2,
      MODE_CHANGE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_RANGE     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture a new request
      logic       scan;       // step the walk pointer and read the entry it names
      logic       shift_wr;   // write the entry read last cycle one place lower
      logic       append;     // write the request value at the end, grow the list
      logic       chg_rd;     // read the entry at the request position
      logic       chg_wr;     // write the request value there, keep the old one
      logic       dec_count;  // shrink the list by one entry
      logic       set_res;    // load the result registers
      logic       set_index;  // result index comes from the entry just compared
      status_type res_code;
      logic       publish;    // move the result to the response channel
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     pos_ok;     // request position is below the live count
      logic     full;       // list is at capacity
      logic     hit;        // entry compared this cycle equals the request value
      logic     walk_done;  // no more entries to read and none in flight
      logic     rsp_free;   // response register can take a new item
   } stat_type;

endpackage

FILE: hw/rtl/plte_ctrl.sv
// ----------------------------------------------------------------------------
// plte_ctrl
// Sequencer for the packed list table engine. Decodes each request and steps
// the datapath through the search, shift, append or change sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plte_ctrl
   import plte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_FIND   = 7'b0000100,
      S_DEL    = 7'b0001000,
      S_CHG_RD = 7'b0010000,
      S_CHG_WR = 7'b0100000,
      S_POST   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_code = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.mode)
               MODE_FIND: begin
                  state_in = S_FIND;
               end
               MODE_DELETE: begin
                  if (stat.pos_ok) begin
                     state_in = S_DEL;
                  end else begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = ST_RANGE;
                     state_in     = S_POST;
                  end
               end
               MODE_APPEND: begin
                  cmd.set_res = 1'b1;
                  if (stat.full) begin
                     cmd.res_code = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
                  state_in = S_POST;
               end
               MODE_CHANGE: begin
                  if (stat.pos_ok) begin
                     state_in = S_CHG_RD;
                  end else begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = ST_RANGE;
                     state_in     = S_POST;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FIND: begin
            if (stat.hit) begin
               cmd.set_res   = 1'b1;
               cmd.set_index = 1'b1;
               state_in      = S_POST;
            end else if (stat.walk_done) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_NOT_FOUND;
               state_in     = S_POST;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_DEL: begin
            if (stat.walk_done) begin
               cmd.dec_count = 1'b1;
               cmd.set_res   = 1'b1;
               state_in      = S_POST;
            end else begin
               cmd.scan     = 1'b1;
               cmd.shift_wr = 1'b1;
            end
         end
         S_CHG_RD: begin
            cmd.chg_rd = 1'b1;
            state_in   = S_CHG_WR;
         end
         S_CHG_WR: begin
            cmd.chg_wr  = 1'b1;
            cmd.set_res = 1'b1;
            state_in    = S_POST;
         end
         S_POST: begin
            if (stat.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/plte_dpath.sv
// ----------------------------------------------------------------------------
// plte_dpath
// Datapath of the packed list table engine: entry memory, live count, walk
// pointer with its one-deep read pipeline, result and response registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plte_dpath
   import plte_pkg::*;
#(
   parameter int DEPTH = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_found_index,
   output logic signed [31:0] rsp_old_value,
   output logic [8:0]         rsp_count,
   input  cmd_type            cmd,
   output stat_type           stat
);

   localparam int CAP = (DEPTH < 256) ? DEPTH : 256;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CW  = $clog2(CAP + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAP);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic signed [31:0] mem [CAP];

   mode_type           mode_ff;
   logic [7:0]         pos_ff;
   logic signed [31:0] val_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               chk_ff, chk_in;
   logic [CW-1:0]      chk_idx_ff, chk_idx_in;
   logic signed [31:0] rd_data_ff;

   status_type         res_status_ff;
   logic [7:0]         res_index_ff;
   logic signed [31:0] res_old_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [7:0]         rsp_index_ff;
   logic signed [31:0] rsp_old_ff;
   logic [CW-1:0]      rsp_count_ff;

   logic               more;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   assign more = (idx_ff < count_ff);

   assign stat.mode      = mode_ff;
   assign stat.pos_ok    = ({1'b0, pos_ff} < 9'(count_ff));
   assign stat.full      = (count_ff >= CAP_C);
   assign stat.hit       = chk_ff && (rd_data_ff == val_ff);
   assign stat.walk_done = !chk_ff && !more;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Memory port selection.
   always_comb begin
      rd_en   = (cmd.scan && more) || cmd.chg_rd;
      rd_addr = cmd.chg_rd ? pos_ff[AW-1:0] : idx_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = val_ff;
      if (cmd.shift_wr && chk_ff) begin
         // The entry read last cycle moves down one place to close the gap.
         wr_en   = 1'b1;
         wr_addr = AW'(chk_idx_ff - ONE_C);
         wr_data = rd_data_ff;
      end else if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
      end else if (cmd.chg_wr) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Walk pointer and live count.
   always_comb begin
      idx_in     = idx_ff;
      chk_in     = chk_ff;
      chk_idx_in = chk_idx_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         chk_in = 1'b0;
         if (mode_type'(req_mode) == MODE_DELETE) begin
            idx_in = CW'(9'(req_position) + 9'd1);
         end else begin
            idx_in = '0;
         end
      end else if (cmd.scan) begin
         if (more) begin
            idx_in     = idx_ff + ONE_C;
            chk_in     = 1'b1;
            chk_idx_in = idx_ff;
         end else begin
            chk_in = 1'b0;
         end
      end
      if (cmd.append) begin
         count_in = count_ff + ONE_C;
      end else if (cmd.dec_count) begin
         count_in = count_ff - ONE_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         chk_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         res_index_ff  <= cmd.set_index ? 8'(chk_idx_ff) : 8'd0;
         res_old_ff    <= cmd.chg_wr ? rd_data_ff : 32'sd0;
      end
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_old_ff    <= res_old_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   // Response register: held while the receiver stalls.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_old_value   = rsp_old_ff;
   assign rsp_count       = 9'(rsp_count_ff);

endmodule

FILE: hw/rtl/packed_list_table_engine_top.sv
// ----------------------------------------------------------------------------
// packed_list_table_engine_top
// Packed list of signed 32-bit entries with find, delete, append and change.
// ----------------------------------------------------------------------------
// Each request item (mode, position, value) enters on the req_ channel and
// produces exactly one response item (status, found index, old value, count)
// on the rsp_ channel. An item is taken when valid is high and stall is low.
// The list holds at most min(DEPTH, 256) entries in a single-port-read,
// single-port-write memory.
// One request is worked on at a time; req_stall is high from acceptance
// until the result is loaded into the response register. Each request is
// first decoded; append and any out-of-range request then load their result
// directly, change reads the entry at the position and then writes it, find
// reads entries from index 0 until the first match or the end of the list,
// and delete moves each entry above the position down one place.
// The next request is taken at the earliest in the cycle after the response
// is loaded.
// A stalled receiver holds the response register, and a finished result
// waits in the block until that register is free. Reset empties the list
// at once with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_list_table_engine_top
   import plte_pkg::*;
#(
   parameter int DEPTH = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_found_index,
   output logic signed [31:0] rsp_old_value,
   output logic [8:0]         rsp_count
);

   cmd_type  cmd;
   stat_type stat;

   plte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   plte_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_old_value   (rsp_old_value),
      .rsp_count       (rsp_count),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed list table engine. A list predictor
// runs beside the block and works out each response as its request is taken.
// A short directed pass covers the empty list, the value extremes, lowest
// match, out-of-range positions and the shift on delete. Random traffic
// then grows the list, fills it to capacity, and shrinks it again, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import plte_pkg::*;

   localparam int LIST_CAP = 256;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      status_type         status;
      logic [7:0]         found_index;
      logic signed [31:0] old_value;
      logic [8:0]         count;
   } list_result;

   typedef struct {
      mode_type           mode;
      logic [7:0]         position;
      logic signed [31:0] value;
      bit                 typed;
      list_result         want;
   } stim_row;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode = MODE_FIND;
   logic [7:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_found_index;
   logic signed [31:0] rsp_old_value;
   logic [8:0]         rsp_count;

   logic signed [31:0] list_mem [0:LIST_CAP-1];
   int                 list_len = 0;
   list_result         pending_results [$];
   stim_row            stim_rows [$];
   int                 mismatches = 0;
   int                 responses = 0;
   int                 stall_left = 0;
   bit                 calm = 1'b0;

   packed_list_table_engine_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_old_value   (rsp_old_value),
      .rsp_count       (rsp_count)
   );

   always #6 clock = ~clock;

   initial begin
      #15ms;
      $display("Some tests failed");
      $finish;
   end

   // Applies one request to the predicted list and returns its response.
   function automatic list_result list_apply(input mode_type m, input logic [7:0] pos,
                                             input logic signed [31:0] val);
      list_result r;
      r.status      = ST_OK;
      r.found_index = '0;
      r.old_value   = '0;
      case (m)
         MODE_FIND: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < list_len; i++) begin
               if (list_mem[i] == val) begin
                  r.status      = ST_OK;
                  r.found_index = i[7:0];
                  break;
               end
            end
         end
         MODE_DELETE: begin
            if (int'(pos) >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_len; i++)
                  list_mem[i] = list_mem[i + 1];
               list_len--;
            end
         end
         MODE_APPEND: begin
            if (list_len >= LIST_CAP) begin
               r.status = ST_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         default: begin
            if (int'(pos) >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               r.old_value   = list_mem[pos];
               list_mem[pos] = val;
            end
         end
      endcase
      r.count = list_len[8:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0d ns, response %0d: %s", $time, responses, msg);
      mismatches++;
   endtask

   // Mostly no wait or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (list_len > 0 && r < 45)
         return list_mem[$urandom_range(0, list_len - 1)];
      if (r < 50)
         return 32'sh7fffffff;
      if (r < 55)
         return 32'sh80000000;
      if (r < 60)
         return $urandom_range(0, 7);
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_position();
      if (list_len > 0 && $urandom_range(0, 99) < 80)
         return 8'($urandom_range(0, list_len - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic mode_type pick_mode(input int w_find, input int w_del, input int w_app,
                                          input int w_chg);
      int r;
      r = $urandom_range(0, w_find + w_del + w_app + w_chg - 1);
      if (r < w_find)
         return MODE_FIND;
      if (r < w_find + w_del)
         return MODE_DELETE;
      if (r < w_find + w_del + w_app)
         return MODE_APPEND;
      return MODE_CHANGE;
   endfunction

   // Called at a falling edge; returns at the falling edge where the next item may start.
   task automatic send_item(input mode_type m, input logic [7:0] pos,
                            input logic signed [31:0] val, input bit typed,
                            input list_result want);
      list_result got;
      int         gap;
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      got = list_apply(m, pos, val);
      pending_results.push_back(typed ? want : got);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_random(input int w_find, input int w_del, input int w_app,
                              input int w_chg);
      list_result none;
      none = '{ST_OK, 8'd0, 32'sd0, 9'd0};
      send_item(pick_mode(w_find, w_del, w_app, w_chg), pick_position(), pick_value(),
                1'b0, none);
   endtask

   task automatic add_row(input mode_type m, input logic [7:0] pos,
                          input logic signed [31:0] val, input bit typed,
                          input status_type st, input logic [7:0] idx,
                          input logic signed [31:0] old, input logic [8:0] cnt);
      stim_row row;
      row.mode     = m;
      row.position = pos;
      row.value    = val;
      row.typed    = typed;
      row.want     = '{st, idx, old, cnt};
      stim_rows.push_back(row);
   endtask

   // Response side: random stall pattern, changed at the falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      list_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_status != want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_found_index != want.found_index)
               report_mismatch($sformatf("found_index %0d, want %0d", rsp_found_index,
                                         want.found_index));
            if (rsp_old_value != want.old_value)
               report_mismatch($sformatf("old_value %0d, want %0d", rsp_old_value,
                                         want.old_value));
            if (rsp_count != want.count)
               report_mismatch($sformatf("count %0d, want %0d", rsp_count, want.count));
         end
      end
   end

   initial begin
      int wait_cycles;

      // Empty list, extremes, lowest match, out-of-range positions, shift on delete.
      add_row(MODE_FIND,   8'd0,   32'sd0,           1, ST_NOT_FOUND, 8'd0, 32'sd0, 9'd0);
      add_row(MODE_DELETE, 8'd0,   32'sd0,           1, ST_RANGE,     8'd0, 32'sd0, 9'd0);
      add_row(MODE_CHANGE, 8'd255, 32'sh12345678,    1, ST_RANGE,     8'd0, 32'sd0, 9'd0);
      add_row(MODE_APPEND, 8'd0,   32'sh7fffffff,    1, ST_OK,        8'd0, 32'sd0, 9'd1);
      add_row(MODE_APPEND, 8'd255, 32'sh80000000,    1, ST_OK,        8'd0, 32'sd0, 9'd2);
      add_row(MODE_APPEND, 8'd0,   -32'sd1,          1, ST_OK,        8'd0, 32'sd0, 9'd3);
      add_row(MODE_APPEND, 8'd0,   32'sd0,           1, ST_OK,        8'd0, 32'sd0, 9'd4);
      add_row(MODE_FIND,   8'd0,   32'sh80000000,    1, ST_OK,        8'd1, 32'sd0, 9'd4);
      add_row(MODE_FIND,   8'd0,   -32'sd1,          1, ST_OK,        8'd2, 32'sd0, 9'd4);
      add_row(MODE_FIND,   8'd0,   32'sd12345,       1, ST_NOT_FOUND, 8'd0, 32'sd0, 9'd4);
      add_row(MODE_CHANGE, 8'd0,   -32'sd1,          1, ST_OK,        8'd0, 32'sh7fffffff,
              9'd4);
      add_row(MODE_FIND,   8'd0,   -32'sd1,          1, ST_OK,        8'd0, 32'sd0, 9'd4);
      add_row(MODE_FIND,   8'd0,   32'sh7fffffff,    1, ST_NOT_FOUND, 8'd0, 32'sd0, 9'd4);
      add_row(MODE_CHANGE, 8'd4,   32'sd5,           1, ST_RANGE,     8'd0, 32'sd0, 9'd4);
      add_row(MODE_DELETE, 8'd4,   32'sd0,           1, ST_RANGE,     8'd0, 32'sd0, 9'd4);
      add_row(MODE_DELETE, 8'd1,   32'sd0,           1, ST_OK,        8'd0, 32'sd0, 9'd3);
      add_row(MODE_FIND,   8'd0,   32'sd0,           0, ST_OK,        8'd0, 32'sd0, 9'd0);
      add_row(MODE_DELETE, 8'd2,   32'sd0,           0, ST_OK,        8'd0, 32'sd0, 9'd0);
      add_row(MODE_CHANGE, 8'd255, 32'sh5555aaaa,    1, ST_RANGE,     8'd0, 32'sd0, 9'd2);
      add_row(MODE_DELETE, 8'd0,   32'sd0,           0, ST_OK,        8'd0, 32'sd0, 9'd0);
      add_row(MODE_DELETE, 8'd0,   32'sd0,           0, ST_OK,        8'd0, 32'sd0, 9'd0);
      add_row(MODE_DELETE, 8'd0,   32'sd0,           1, ST_RANGE,     8'd0, 32'sd0, 9'd0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i])
         send_item(stim_rows[i].mode, stim_rows[i].position, stim_rows[i].value,
                   stim_rows[i].typed, stim_rows[i].want);

      // Mixed traffic on a short list, with one stretch free of gaps and stalls.
      for (int n = 0; n < 100; n++) begin
         calm = (n >= 40 && n < 70);
         send_random(30, 20, 30, 20);
      end
      calm = 1'b0;

      // Hold the request side until every response is back.
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      @(negedge clock);

      // Grow the list to capacity, then work on the full list.
      while (list_len < LIST_CAP)
         send_random(5, 4, 85, 6);
      for (int n = 0; n < 12; n++)
         send_random(30, 0, 40, 30);

      // Drain-heavy traffic, which walks long shifts on the large list.
      for (int n = 0; n < 120; n++) begin
         calm = (n >= 60 && n < 80);
         send_random(25, 45, 15, 15);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      wait (pending_results.size() == 0);
      wait_cycles = 0;
      while (wait_cycles < DRAIN_CYCLES) begin
         @(posedge clock);
         wait_cycles++;
      end

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
